>>> src/slcg_pkg.sv
// ----------------------------------------------------------------------------
// slcg_pkg - shared constants, types and functions
// Constants and helpers for the shuffled minimal-standard random generator.
// ----------------------------------------------------------------------------
`default_nettype none

package slcg_pkg;

  // Number of entries in the shuffle table
  localparam int TABLE_SIZE   = 32;
  localparam int IDX_W        = $clog2(TABLE_SIZE);

  // Value width and multiplier constants
  localparam int VAL_W        = 31;
  localparam int MULT_W       = 15;
  localparam int PROD_W       = VAL_W + MULT_W;
  localparam int SUM_W        = VAL_W + 1;

  localparam logic [MULT_W-1:0] LCG_MULT = MULT_W'(16807);
  localparam logic [VAL_W-1:0]  LCG_MOD  = VAL_W'(2147483647);

  // Warm-up steps before the table is filled
  localparam int WARMUP_STEPS = 8;
  localparam int LAST_STEP    = WARMUP_STEPS + TABLE_SIZE - 1;
  localparam int CNT_W        = $clog2(LAST_STEP + 1);

  // Divisor that maps a previous output onto a table slot
  localparam logic [VAL_W-1:0] SLOT_DIV =
    VAL_W'(1 + (2147483646 / TABLE_SIZE));

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_FOLD = 5'b00100,
    ST_READ = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  // Reduce x*16807 modulo 2^31-1: fold high bits onto low bits, one subtract.
  function automatic logic [VAL_W-1:0] lcg_fold(input logic [PROD_W-1:0] prod);
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] mod_ext;
    begin
      mod_ext = SUM_W'(LCG_MOD);
      sum = SUM_W'(prod[VAL_W-1:0]) + SUM_W'(prod[PROD_W-1:VAL_W]);
      if (sum >= mod_ext) begin
        sum = sum - mod_ext;
      end
      lcg_fold = sum[VAL_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> src/slcg_ram.sv
// ----------------------------------------------------------------------------
// slcg_ram - generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module slcg_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> src/shuffled_lcg_random_generator.sv
// Sequence: an accepted item passes ST_MUL, ST_FOLD, ST_READ and ST_DONE, and
//   out_valid rises as ST_DONE is left. A new item is taken only in ST_IDLE;
//   every generator step runs through the shared multiply / fold unit.
// Seeding (first item, reseed set, or state zero) adds 40 steps.
// Reset (rst_n low, synchronous): sequencer idle, no result pending,
//   seed = 1, generator and previous output cleared so the next item seeds.
// ----------------------------------------------------------------------------
// shuffled_lcg_random_generator - shuffled minimal-standard generator
// Park-Miller generator (x*16807 mod 2^31-1) behind a 32-entry shuffle table.
// ----------------------------------------------------------------------------
`default_nettype none

module shuffled_lcg_random_generator (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // request channel
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_reseed,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [slcg_pkg::VAL_W-1:0]       out_value,
  // seed register write
  input  wire logic                        cfg_wr_en,
  input  wire logic [slcg_pkg::VAL_W-1:0]  cfg_wr_data
);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  slcg_pkg::state_t                  state_r, state_nxt;
  logic [slcg_pkg::VAL_W-1:0]        seed_r;
  logic [slcg_pkg::VAL_W-1:0]        gen_r, gen_nxt;       // generator value
  logic [slcg_pkg::VAL_W-1:0]        prev_r, prev_nxt;     // previous output
  logic [slcg_pkg::VAL_W-1:0]        x_r, x_nxt;           // step operand
  logic [slcg_pkg::PROD_W-1:0]       prod_r;               // multiplier output
  logic [slcg_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;       // seeding step count
  logic                              seeding_r, seeding_nxt;
  logic [slcg_pkg::IDX_W-1:0]        slot_r, slot_nxt;     // picked table slot
  logic [slcg_pkg::VAL_W-1:0]        pick_r, pick_nxt;     // picked entry
  logic                              out_valid_r;
  logic [slcg_pkg::VAL_W-1:0]        out_value_r;

  // --------------------------------------------------------------------------
  // Shared step unit: multiply in ST_MUL, fold modulo 2^31-1 in ST_FOLD
  // --------------------------------------------------------------------------
  logic [slcg_pkg::VAL_W-1:0] step_val;
  assign step_val = slcg_pkg::lcg_fold(prod_r);

  // Seed with the zero and modulus values taken as one
  logic [slcg_pkg::VAL_W-1:0] seed_fix;
  assign seed_fix = (seed_r == '0 || seed_r == slcg_pkg::LCG_MOD) ?
                    slcg_pkg::VAL_W'(1) : seed_r;

  // Table slot from the previous output, clamped as a guard
  logic [slcg_pkg::VAL_W-1:0] slot_wide;
  logic [slcg_pkg::IDX_W-1:0] slot_calc;
  assign slot_wide = prev_r / slcg_pkg::SLOT_DIV;
  assign slot_calc = (slot_wide >= slcg_pkg::VAL_W'(slcg_pkg::TABLE_SIZE)) ?
                     slcg_pkg::IDX_W'(slcg_pkg::TABLE_SIZE - 1) :
                     slot_wide[slcg_pkg::IDX_W-1:0];

  // Fill order: entries TABLE_SIZE-1 down to 0 after the warm-up steps
  logic [slcg_pkg::CNT_W-1:0] fill_idx;
  assign fill_idx = slcg_pkg::CNT_W'(slcg_pkg::LAST_STEP) - cnt_r;

  // --------------------------------------------------------------------------
  // Shuffle table
  // --------------------------------------------------------------------------
  logic                        ram_we;
  logic [slcg_pkg::IDX_W-1:0]  ram_waddr;
  logic [slcg_pkg::VAL_W-1:0]  ram_wdata;
  logic                        ram_re;
  logic [slcg_pkg::VAL_W-1:0]  ram_rdata;

  slcg_ram #(
    .WIDTH (slcg_pkg::VAL_W),
    .DEPTH (slcg_pkg::TABLE_SIZE)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (slot_calc),
    .rd_data (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  logic in_acc;
  logic out_free;
  assign in_ready  = (state_r == slcg_pkg::ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt   = state_r;
    gen_nxt     = gen_r;
    prev_nxt    = prev_r;
    x_nxt       = x_r;
    cnt_nxt     = cnt_r;
    seeding_nxt = seeding_r;
    slot_nxt    = slot_r;
    pick_nxt    = pick_r;
    ram_we      = 1'b0;
    ram_waddr   = slot_r;
    ram_wdata   = gen_r;
    ram_re      = 1'b0;

    case (state_r)
      slcg_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = slcg_pkg::ST_MUL;
          cnt_nxt   = '0;
          if (in_reseed || gen_r == '0 || prev_r == '0) begin
            seeding_nxt = 1'b1;
            x_nxt       = seed_fix;
          end else begin
            seeding_nxt = 1'b0;
            x_nxt       = gen_r;
          end
        end
      end
      slcg_pkg::ST_MUL: begin
        state_nxt = slcg_pkg::ST_FOLD;
      end
      slcg_pkg::ST_FOLD: begin
        x_nxt = step_val;
        if (seeding_r) begin
          state_nxt = slcg_pkg::ST_MUL;
          if (cnt_r >= slcg_pkg::CNT_W'(slcg_pkg::WARMUP_STEPS)) begin
            ram_we    = 1'b1;
            ram_waddr = fill_idx[slcg_pkg::IDX_W-1:0];
            ram_wdata = step_val;
          end
          if (cnt_r == slcg_pkg::CNT_W'(slcg_pkg::LAST_STEP)) begin
            // table full; entry 0 was just written with this value
            gen_nxt     = step_val;
            prev_nxt    = step_val;
            seeding_nxt = 1'b0;
          end else begin
            cnt_nxt = cnt_r + slcg_pkg::CNT_W'(1);
          end
        end else begin
          gen_nxt   = step_val;
          ram_re    = 1'b1;
          slot_nxt  = slot_calc;
          state_nxt = slcg_pkg::ST_READ;
        end
      end
      slcg_pkg::ST_READ: begin
        // read data is the old entry; replace it with the new generator value
        pick_nxt  = ram_rdata;
        prev_nxt  = ram_rdata;
        ram_we    = 1'b1;
        ram_waddr = slot_r;
        ram_wdata = gen_r;
        state_nxt = slcg_pkg::ST_DONE;
      end
      slcg_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = slcg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = slcg_pkg::ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= slcg_pkg::ST_IDLE;
      seed_r      <= slcg_pkg::VAL_W'(1);
      gen_r       <= '0;
      prev_r      <= '0;
      seeding_r   <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      gen_r     <= gen_nxt;
      prev_r    <= prev_nxt;
      seeding_r <= seeding_nxt;
      cnt_r     <= cnt_nxt;
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
      if (state_r == slcg_pkg::ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    x_r      <= x_nxt;
    prod_r   <= slcg_pkg::PROD_W'(x_r) * slcg_pkg::PROD_W'(slcg_pkg::LCG_MULT);
    slot_r   <= slot_nxt;
    pick_r   <= pick_nxt;
    if (state_r == slcg_pkg::ST_DONE && out_free) begin
      out_value_r <= pick_r;
    end
  end

endmodule

`default_nettype wire

>>> src/slcg_checker.sv
// ----------------------------------------------------------------------------
// slcg_checker - port-level checks for the shuffled generator
// Watches the top-level ports and flags ordering and range violations.
// ----------------------------------------------------------------------------
`default_nettype none

module slcg_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [slcg_pkg::VAL_W-1:0] out_value
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value))
    else $error("result changed while stalled");

  // results lie strictly between zero and the modulus
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_value != '0 && out_value != slcg_pkg::LCG_MOD)
    else $error("result out of range");

  // one item at a time: busy right after an accepted item
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while busy");

  // reset leaves no result pending
  a_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result pending after reset");

endmodule

bind shuffled_lcg_random_generator slcg_checker u_slcg_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_value   (out_value)
);

`default_nettype wire

>>> bench/tb_shuffled_lcg_random_generator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_shuffled_lcg_random_generator - self-checking bench for the generator
// Drives requests with random reseeds and seed writes. Each value is checked
// against an in-bench model of the shuffled 16807 generator.
// ----------------------------------------------------------------------------

module tb_shuffled_lcg_random_generator;

  typedef logic [slcg_pkg::VAL_W-1:0] value_t;

  localparam int              CLK_HALF       = 5;
  localparam int              WARMUP         = 8;
  localparam int              SHUFFLE_DEPTH  = slcg_pkg::TABLE_SIZE;
  localparam longint unsigned MULTIPLIER     = 16807;
  localparam longint unsigned MODULUS        = 64'd2147483647;
  localparam longint unsigned SLOT_WIDTH     = 1 + (MODULUS - 1) / SHUFFLE_DEPTH;
  localparam value_t          SEED_MAX       = value_t'(2147483646);
  localparam value_t          SEED_ALL_ONES  = value_t'(2147483647);
  localparam int              RANDOM_ITEMS   = 1630;
  // Covers a reseed plus the longest receiver stall and sender gap.
  localparam int              WATCHDOG_LIMIT = 2000;

  logic   clk = 1'b0;
  logic   rst_n;
  logic   in_valid;
  logic   in_ready;
  logic   in_reseed;
  logic   out_valid;
  logic   out_ready;
  value_t out_value;
  logic   cfg_wr_en;
  value_t cfg_wr_data;

  // Model of the generator state
  value_t seed_reg;
  value_t gen_state;
  value_t last_pick;
  value_t shuffle [SHUFFLE_DEPTH];

  value_t expected_values[$];
  value_t want;
  int     errors;
  int     requests_sent;
  int     reseeds_sent;
  int     values_checked;
  int     seed_writes;
  int     idle_cycles;
  int     stall_left;
  bit     steady;   // both sides run without gaps

  shuffled_lcg_random_generator dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_reseed   (in_reseed),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_value   (out_value),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #CLK_HALF clk = ~clk;

  // --------------------------------------------------------------------------
  // Model
  // --------------------------------------------------------------------------

  // x * 16807 mod (2^31 - 1), done directly in 64 bits
  function automatic value_t lcg_step(input value_t x);
    longint unsigned prod;
    prod = longint'(x) * MULTIPLIER;
    return value_t'(prod % MODULUS);
  endfunction

  // Load the seed, warm up, then fill the table from the top entry down
  function automatic void refill_shuffle();
    value_t x;
    int     j;
    x = seed_reg;
    // zero and the modulus itself would lock the generator at zero
    if (x == '0 || x == SEED_ALL_ONES) begin
      x = value_t'(1);
    end
    for (j = 0; j < WARMUP; j++) begin
      x = lcg_step(x);
    end
    for (j = SHUFFLE_DEPTH - 1; j >= 0; j--) begin
      x = lcg_step(x);
      shuffle[j] = x;
    end
    gen_state = x;
    last_pick = shuffle[0];
  endfunction

  // Value the block returns for one request
  function automatic value_t shuffled_value(input bit reseed);
    longint unsigned slot;
    value_t          picked;
    // state still zero means first use since reset
    if (reseed || gen_state == '0 || last_pick == '0) begin
      refill_shuffle();
    end
    gen_state = lcg_step(gen_state);
    slot = longint'(last_pick) / SLOT_WIDTH;
    if (slot >= SHUFFLE_DEPTH) begin
      slot = SHUFFLE_DEPTH - 1;
    end
    picked        = shuffle[slot];
    shuffle[slot] = gen_state;
    last_pick     = picked;
    return picked;
  endfunction

  // --------------------------------------------------------------------------
  // Gaps: mostly none or short, now and then long
  // --------------------------------------------------------------------------

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Receiver: random stalls, none while steady
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (steady || $urandom_range(0, 99) < 65) begin
      out_ready <= 1'b1;
    end else begin
      out_ready  <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) :
                                                  $urandom_range(0, 2);
    end
  end

  // --------------------------------------------------------------------------
  // Result check and watchdog
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles, %0d values still due",
               $time, idle_cycles, expected_values.size());
      $display("TB_ERROR");
      $finish;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (out_valid && out_ready) begin
        if (expected_values.size() == 0) begin
          errors++;
          $display("%0t: value %0d with nothing expected", $time, out_value);
        end else begin
          want = expected_values.pop_front();
          values_checked++;
          if (out_value !== want) begin
            errors++;
            $display("%0t: value mismatch, expected %0d, got %0d",
                     $time, want, out_value);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // One request; returns at the edge that accepts it, valid still high
  task automatic send_request(input bit reseed);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_reseed <= reseed;
    do @(posedge clk); while (!in_ready);
    expected_values.push_back(shuffled_value(reseed));
    requests_sent++;
    if (reseed) begin
      reseeds_sent++;
    end
  endtask

  // Stop sending and wait until every value has come back
  task automatic drain_values();
    in_valid <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk);
  endtask

  // Seed write, only with the block idle
  task automatic write_seed(input value_t value);
    drain_values();
    repeat (2) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    seed_reg = value;
    seed_writes++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset seed of 1; the first item seeds without reseed set
  task automatic test_first_request_after_reset();
    repeat (3) send_request(1'b0);
    send_request(1'b1);
  endtask

  // Seed zero and seed equal to the modulus both behave as seed one; max and one run too
  task automatic test_seed_extremes();
    value_t seeds [4];
    int     k;
    seeds = '{value_t'(0), SEED_ALL_ONES, SEED_MAX, value_t'(1)};
    for (k = 0; k < 4; k++) begin
      write_seed(seeds[k]);
      send_request(1'b1);
      repeat (2) send_request(1'b0);
    end
  endtask

  // A new seed only takes effect on the next reseed
  task automatic test_seed_kept_until_reseed();
    write_seed(value_t'(12345));
    repeat (2) send_request(1'b0);
    send_request(1'b1);
    send_request(1'b1);
  endtask

  // Phases with fresh seeds, mostly plain requests, a few reseeds
  task automatic test_random_traffic();
    int     sent;
    int     phase;
    int     count;
    int     n;
    value_t seed_pick;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 3))
          0:       seed_pick = '0;
          1:       seed_pick = value_t'(1);
          2:       seed_pick = SEED_MAX;
          default: seed_pick = SEED_ALL_ONES;
        endcase
      end else begin
        seed_pick = value_t'($urandom());
      end
      write_seed(seed_pick);
      steady = (phase % 4 == 3);
      count  = $urandom_range(60, 180);
      if (count > RANDOM_ITEMS - sent) begin
        count = RANDOM_ITEMS - sent;
      end
      for (n = 0; n < count; n++) begin
        // hold off halfway through until all values are back
        if (n == count / 2) begin
          drain_values();
        end
        send_request($urandom_range(0, 24) == 0);
      end
      sent += count;
      phase++;
    end
    steady = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_reseed   = 1'b0;
    out_ready   = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    stall_left  = 0;
    steady      = 1'b0;
    errors         = 0;
    requests_sent  = 0;
    reseeds_sent   = 0;
    values_checked = 0;
    seed_writes    = 0;
    // model state after reset
    seed_reg  = value_t'(1);
    gen_state = '0;
    last_pick = '0;
    foreach (shuffle[i]) shuffle[i] = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_first_request_after_reset();
    test_seed_extremes();
    test_seed_kept_until_reseed();
    test_random_traffic();

    drain_values();
    repeat (10) @(posedge clk);
    if (expected_values.size() != 0) begin
      errors++;
      $display("%0t: %0d values never came", $time, expected_values.size());
    end

    $display("Covered %0d requests (%0d reseeds) and %0d seed writes,",
             requests_sent, reseeds_sent, seed_writes);
    $display("with seeds at zero, one, max and all ones; %0d values checked.",
             values_checked);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> shuffled_lcg_random_generator.f
src/slcg_pkg.sv
src/slcg_ram.sv
src/shuffled_lcg_random_generator.sv
src/slcg_checker.sv
bench/tb_shuffled_lcg_random_generator.sv
